/* rtl/nlbs_pkg.sv */
`timescale 1ns / 1ps

package nlbs_pkg;

  // timer width, 12 to 32
  localparam int TIMER_BITS = 16;
  localparam int CFG_TIME_W = 16;
  // compare width wide enough for a timer and a configured timeout
  localparam int CMP_W = (TIMER_BITS > CFG_TIME_W) ? TIMER_BITS : CFG_TIME_W;

  // input opcodes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_BOOTUP = 3'd1;
  localparam logic [2:0] OP_HBEAT  = 3'd2;
  localparam logic [2:0] OP_MAPACK = 3'd3;
  localparam logic [2:0] OP_SYNC   = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_TO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HB_WAIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANNOUNCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OP_CODE   = 3'd5;

  // pre-operational steps
  localparam logic [3:0] STEP_IDLE     = 4'd0;
  localparam logic [3:0] STEP_SEND_A   = 4'd1;
  localparam logic [3:0] STEP_WAIT_A   = 4'd2;
  localparam logic [3:0] STEP_SEND_B   = 4'd3;
  localparam logic [3:0] STEP_WAIT_B   = 4'd4;
  localparam logic [3:0] STEP_GO_OP    = 4'd5;
  localparam logic [3:0] STEP_SEND_RM  = 4'd6;
  localparam logic [3:0] STEP_WAIT_RM  = 4'd7;
  localparam logic [3:0] STEP_WAIT_HB  = 4'd8;

  typedef enum logic [1:0] {
    PH_BOOT  = 2'd0,
    PH_PREOP = 2'd1,
    PH_OPER  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_BOOTUP    = 3'd1,
    CMD_HEARTBEAT = 3'd2,
    CMD_MAPPING   = 3'd3,
    CMD_GO_OP     = 3'd4,
    CMD_READ_MASK = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] retry_timeout_ms;
    logic [3:0]            max_retries;
    logic [CFG_TIME_W-1:0] hb_wait_timeout_ms;
    logic [CFG_TIME_W-1:0] announce_period_ms;
    logic [CFG_TIME_W-1:0] activity_timeout_ms;
    logic [7:0]            operational_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] heartbeat_state;
    logic       ack_group;
  } item_t;

  typedef struct packed {
    cmd_t       command;
    logic       map_group;
    phase_t     link_state;
    logic [3:0] sub_state;
    logic       connected;
  } result_t;

endpackage

/* rtl/nlbs_cfg_regs.sv */
`timescale 1ns / 1ps

module nlbs_cfg_regs
  import nlbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_timeout_ms    <= 16'd1000;
      cfg_r.max_retries         <= 4'd3;
      cfg_r.hb_wait_timeout_ms  <= 16'd3000;
      cfg_r.announce_period_ms  <= 16'd1000;
      cfg_r.activity_timeout_ms <= 16'd5000;
      cfg_r.operational_code    <= 8'd5;
    end else if (wr_en) begin
      case (wr_index)
        REG_RETRY_TO:  cfg_r.retry_timeout_ms    <= wr_data;
        REG_MAX_RETRY: cfg_r.max_retries         <= wr_data[3:0];
        REG_HB_WAIT:   cfg_r.hb_wait_timeout_ms  <= wr_data;
        REG_ANNOUNCE:  cfg_r.announce_period_ms  <= wr_data;
        REG_ACTIVITY:  cfg_r.activity_timeout_ms <= wr_data;
        REG_OP_CODE:   cfg_r.operational_code    <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/nlbs_core.sv */
`timescale 1ns / 1ps

module nlbs_core
  import nlbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  phase_t                phase_r, phase_nxt;
  logic [3:0]            step_r, step_nxt;
  logic                  synced_r, synced_nxt;
  logic                  hb_seen_r, hb_seen_nxt;
  logic [3:0]            retry_r, retry_nxt;
  logic [TIMER_BITS-1:0] req_t_r, req_t_nxt;
  logic [TIMER_BITS-1:0] boot_t_r, boot_t_nxt;
  logic [TIMER_BITS-1:0] hb_t_r, hb_t_nxt;
  logic [TIMER_BITS-1:0] act_t_r, act_t_nxt;

  logic [TIMER_BITS-1:0] req_adv, boot_adv, hb_adv, act_adv;
  logic                  req_expired, hb_wait_expired, announce_boot, announce_hb;
  logic                  act_expired;
  logic [3:0]            back_step;
  cmd_t                  cmd;
  logic                  grp;

  // saturating tick advance
  function automatic logic [TIMER_BITS-1:0] advance(input logic [TIMER_BITS-1:0] t);
    advance = (t == TMAX) ? t : t + 1'b1;
  endfunction

  assign req_adv  = advance(req_t_r);
  assign boot_adv = advance(boot_t_r);
  assign hb_adv   = advance(hb_t_r);
  assign act_adv  = advance(act_t_r);

  // timeout compares at a common width
  assign req_expired     = CMP_W'(req_adv) > CMP_W'(cfg.retry_timeout_ms);
  assign hb_wait_expired = CMP_W'(req_adv) > CMP_W'(cfg.hb_wait_timeout_ms);
  assign announce_boot   = CMP_W'(boot_adv) > CMP_W'(cfg.announce_period_ms);
  assign announce_hb     = CMP_W'(hb_adv) > CMP_W'(cfg.announce_period_ms);
  assign act_expired     = CMP_W'(act_adv) > CMP_W'(cfg.activity_timeout_ms);

  // send step to go back to from a wait step
  always_comb begin
    case (step_r)
      STEP_WAIT_A:  back_step = STEP_SEND_A;
      STEP_WAIT_B:  back_step = STEP_SEND_B;
      default:      back_step = STEP_SEND_RM;
    endcase
  end

  // next state and result for one item
  always_comb begin
    phase_nxt   = phase_r;
    step_nxt    = step_r;
    synced_nxt  = synced_r;
    hb_seen_nxt = hb_seen_r;
    retry_nxt   = retry_r;
    req_t_nxt   = req_t_r;
    boot_t_nxt  = boot_t_r;
    hb_t_nxt    = hb_t_r;
    act_t_nxt   = act_t_r;
    cmd         = CMD_NONE;
    grp         = 1'b0;

    case (item.opcode)
      OP_TICK: begin
        req_t_nxt  = req_adv;
        boot_t_nxt = boot_adv;
        hb_t_nxt   = hb_adv;
        act_t_nxt  = act_adv;
        if ((phase_r inside {PH_PREOP, PH_OPER}) && act_expired) begin
          // activity watchdog
          phase_nxt   = PH_STOP;
          step_nxt    = STEP_SEND_A;
          synced_nxt  = 1'b0;
          hb_seen_nxt = 1'b0;
        end else begin
          case (phase_r)
            PH_BOOT: begin
              if (announce_boot) begin
                cmd        = CMD_BOOTUP;
                boot_t_nxt = '0;
              end
            end
            PH_PREOP: begin
              case (step_r)
                STEP_SEND_A: begin
                  cmd       = CMD_MAPPING;
                  step_nxt  = STEP_WAIT_A;
                  req_t_nxt = '0;
                end
                STEP_SEND_B: begin
                  cmd       = CMD_MAPPING;
                  grp       = 1'b1;
                  step_nxt  = STEP_WAIT_B;
                  req_t_nxt = '0;
                end
                STEP_GO_OP: begin
                  cmd       = CMD_GO_OP;
                  step_nxt  = STEP_SEND_RM;
                  req_t_nxt = '0;
                end
                STEP_SEND_RM: begin
                  cmd       = CMD_READ_MASK;
                  step_nxt  = STEP_WAIT_RM;
                  req_t_nxt = '0;
                end
                STEP_WAIT_A, STEP_WAIT_B, STEP_WAIT_RM: begin
                  if (req_expired) begin
                    if (retry_r < cfg.max_retries) begin
                      step_nxt  = back_step;
                      retry_nxt = retry_r + 4'd1;
                    end else begin
                      phase_nxt = PH_STOP;
                      retry_nxt = 4'd0;
                    end
                  end
                end
                STEP_WAIT_HB: begin
                  if (hb_seen_r) begin
                    hb_seen_nxt = 1'b0;
                    step_nxt    = STEP_IDLE;
                    phase_nxt   = PH_OPER;
                  end else if (hb_wait_expired) begin
                    phase_nxt = PH_STOP;
                    retry_nxt = 4'd0;
                  end
                end
                default: ;
              endcase
            end
            PH_OPER: begin
              if (announce_hb) begin
                cmd      = CMD_HEARTBEAT;
                hb_t_nxt = '0;
              end
            end
            default: begin
              // stopped: back to boot-up, sequence re-armed
              phase_nxt   = PH_BOOT;
              step_nxt    = STEP_SEND_A;
              synced_nxt  = 1'b0;
              hb_seen_nxt = 1'b0;
            end
          endcase
        end
      end
      OP_BOOTUP: begin
        act_t_nxt = '0;
        if (phase_r inside {PH_BOOT, PH_PREOP}) begin
          phase_nxt = PH_PREOP;
          if (step_r != STEP_IDLE) begin
            step_nxt    = STEP_SEND_A;
            retry_nxt   = 4'd0;
            hb_seen_nxt = 1'b0;
          end
        end
      end
      OP_HBEAT: begin
        act_t_nxt = '0;
        if (item.heartbeat_state == cfg.operational_code) begin
          hb_seen_nxt = 1'b1;
        end
      end
      OP_MAPACK: begin
        step_nxt  = item.ack_group ? STEP_GO_OP : STEP_SEND_B;
        retry_nxt = 4'd0;
      end
      OP_SYNC: begin
        synced_nxt = 1'b1;
        step_nxt   = STEP_WAIT_HB;
        req_t_nxt  = '0;
      end
      default: ;
    endcase
  end

  // state update on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_BOOT;
      step_r    <= STEP_SEND_A;
      synced_r  <= 1'b0;
      hb_seen_r <= 1'b0;
      retry_r   <= 4'd0;
      req_t_r   <= '0;
      boot_t_r  <= '0;
      hb_t_r    <= '0;
      act_t_r   <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      step_r    <= step_nxt;
      synced_r  <= synced_nxt;
      hb_seen_r <= hb_seen_nxt;
      retry_r   <= retry_nxt;
      req_t_r   <= req_t_nxt;
      boot_t_r  <= boot_t_nxt;
      hb_t_r    <= hb_t_nxt;
      act_t_r   <= act_t_nxt;
    end
  end

  assign result.command    = cmd;
  assign result.map_group  = grp;
  assign result.link_state = phase_nxt;
  assign result.sub_state  = step_nxt;
  assign result.connected  = (phase_nxt == PH_OPER) && synced_nxt;

endmodule

/* rtl/node_link_bringup_supervisor.sv */
`timescale 1ns / 1ps

// Bring-up supervisor for one CAN node, master side.
// Input channel (in_valid / in_stall): one item per transfer, either a 1 ms
// tick or an event from the node (bootup, heartbeat, mapping ack, sync
// response). Every item gives exactly one result on the output channel
// (out_valid / out_stall): command to send, mapping group, link state,
// pre-operational sub-state and connected flag.
// Path: the item sits in the input register, the core computes its state
// update and result, and the result register loads them as the item leaves.
// Throughput: one item per cycle while the receiver does not stall, with the
// state update in the core combinational between the two registers.
// Receiver stall: the result register holds; the input register fills, and
// in_stall rises only while both registers hold an item.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready; the
// user writes only while the block is idle (not enforced); unknown indexes ignored.
// Reset (rst_n low, synchronous): link in boot-up at the first mapping step,
// timers and flags cleared, registers at their defaults, channels empty.

module node_link_bringup_supervisor
  import nlbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_opcode,
  input  logic [7:0]           in_heartbeat_state,
  input  logic                 in_ack_group,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_command,
  output logic                 out_map_group,
  output logic [1:0]           out_link_state,
  output logic [3:0]           out_sub_state,
  output logic                 out_connected,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  logic    out_vld_r;
  result_t res;
  result_t res_r;
  logic    advance_en;
  logic    in_xfer;

  assign cfg_ready = 1'b1;

  nlbs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // item moves on when the result register is free or being emptied
  assign advance_en = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall   = in_vld_r && !advance_en;
  assign in_xfer    = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.opcode          <= in_opcode;
      item_r.heartbeat_state <= in_heartbeat_state;
      item_r.ack_group       <= in_ack_group;
    end
  end

  nlbs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance_en),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance_en) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_en) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_command    = res_r.command;
  assign out_map_group  = res_r.map_group;
  assign out_link_state = res_r.link_state;
  assign out_sub_state  = res_r.sub_state;
  assign out_connected  = res_r.connected;

endmodule
